### sv/cna_pkg.sv
// shared types, widths, codes and rounding helpers of the complex alu
package cna_pkg;

	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;

	// job operand width: holds a sum of two words or the magnitude of a word
	localparam int JW = WORD_BITS + 2;
	// wide datapath width for rounded products and quotients
	localparam int XW_A = WORD_BITS + FRAC_BITS + 4;
	localparam int XW_B = 2 * WORD_BITS - FRAC_BITS + 2;
	localparam int XW = (XW_A > XW_B) ? XW_A : XW_B;
	// shared multiplier
	localparam int MW = WORD_BITS + 2;
	localparam int PW = 2 * MW;
	// divider: numerator and divisor magnitude, dividend width
	localparam int NMW = WORD_BITS + 2;
	localparam int DVW = NMW + FRAC_BITS + 1;
	// square root: radicand, root and remainder widths
	localparam int SQW = 2 * FRAC_BITS + 2;
	localparam int SRW = FRAC_BITS + 1;
	localparam int SMW = FRAC_BITS + 3;

	localparam int QUEUE_DEPTH = 4;

	localparam logic signed [JW-1:0] ONE_Q = JW'(2 ** FRAC_BITS);
	localparam logic [PW-1:0] RND_HALF = PW'(2 ** (FRAC_BITS - 1));

	// opcodes
	localparam logic [3:0] OP_NEG   = 4'd0;
	localparam logic [3:0] OP_ADD   = 4'd1;
	localparam logic [3:0] OP_SUB   = 4'd2;
	localparam logic [3:0] OP_MUL   = 4'd3;
	localparam logic [3:0] OP_DIV   = 4'd4;
	localparam logic [3:0] OP_CONJ  = 4'd5;
	localparam logic [3:0] OP_RECIP = 4'd6;
	localparam logic [3:0] OP_SCALE = 4'd7;
	localparam logic [3:0] OP_MAG   = 4'd8;

	typedef enum logic [2:0] {
		K_DONE,
		K_MUL,
		K_SCALE,
		K_SMITH,
		K_MAG
	} kind_t;

	typedef struct packed {
		logic [3:0]                  op;
		logic signed [WORD_BITS-1:0] a_re;
		logic signed [WORD_BITS-1:0] a_im;
		logic signed [WORD_BITS-1:0] b_re;
		logic signed [WORD_BITS-1:0] b_im;
	} in_t;

	typedef struct packed {
		logic signed [WORD_BITS-1:0] res_re;
		logic signed [WORD_BITS-1:0] res_im;
		logic                        div_zero;
		logic                        overflow;
		logic                        operands_equal;
	} out_t;

	// classified work item; for smith jobs x/y are the arranged numerators,
	// p the larger divisor part and q the smaller one
	typedef struct packed {
		kind_t                kind;
		logic                 swap;
		logic                 div_zero;
		logic                 operands_equal;
		logic signed [JW-1:0] x;
		logic signed [JW-1:0] y;
		logic signed [JW-1:0] p;
		logic signed [JW-1:0] q;
	} job_t;

	typedef struct packed {
		logic                 start;
		logic signed [XW-1:0] num;
		logic signed [XW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic signed [XW-1:0] quot;
	} div_rsp_t;

	typedef struct packed {
		logic signed [WORD_BITS-1:0] v;
		logic                        ov;
	} sat_t;

	// round an exact product to the fraction, ties toward plus infinity
	function automatic logic signed [XW-1:0] qround(input logic signed [PW-1:0] p);
		logic signed [PW-1:0] t;
		t = p + $signed(RND_HALF);
		return XW'(t >>> FRAC_BITS);
	endfunction

	// clamp a wide value to the word range
	function automatic sat_t saturate(input logic signed [XW-1:0] x);
		sat_t s;
		if (x[XW-1:WORD_BITS-1] == '0 || x[XW-1:WORD_BITS-1] == '1) begin
			s.v  = x[WORD_BITS-1:0];
			s.ov = 1'b0;
		end else begin
			s.ov = 1'b1;
			s.v  = x[XW-1] ? {1'b1, {(WORD_BITS-1){1'b0}}} : {1'b0, {(WORD_BITS-1){1'b1}}};
		end
		return s;
	endfunction

endpackage

### sv/cna_front.sv
// front end: classifies a transaction, does the trivial ops, arranges operands
module cna_front (
	input  cna_pkg::in_t  item,
	output cna_pkg::job_t job
);

	logic signed [cna_pkg::JW-1:0] are, aim, bre, bim;
	logic signed [cna_pkg::JW-1:0] abs_ar, abs_ai, dc, dd, ac, ad;
	logic signed [cna_pkg::JW-1:0] nx, ny, hi, lo;
	logic                          a_zero, b_zero, swap;

	always_comb begin
		are = cna_pkg::JW'(item.a_re);
		aim = cna_pkg::JW'(item.a_im);
		bre = cna_pkg::JW'(item.b_re);
		bim = cna_pkg::JW'(item.b_im);
		abs_ar = are[cna_pkg::JW-1] ? -are : are;
		abs_ai = aim[cna_pkg::JW-1] ? -aim : aim;
		a_zero = (item.a_re == '0) && (item.a_im == '0);
		b_zero = (item.b_re == '0) && (item.b_im == '0);

		// divisor and numerator for smith: divide uses a over b, reciprocal 1 over a
		dc = (item.op == cna_pkg::OP_RECIP) ? are : bre;
		dd = (item.op == cna_pkg::OP_RECIP) ? aim : bim;
		nx = (item.op == cna_pkg::OP_RECIP) ? cna_pkg::ONE_Q : are;
		ny = (item.op == cna_pkg::OP_RECIP) ? '0 : aim;
		ac = dc[cna_pkg::JW-1] ? -dc : dc;
		ad = dd[cna_pkg::JW-1] ? -dd : dd;
		swap = !(ad < ac);

		// magnitude ordering
		hi = (abs_ar < abs_ai) ? abs_ai : abs_ar;
		lo = (abs_ar < abs_ai) ? abs_ar : abs_ai;

		job = '0;
		job.kind = cna_pkg::K_DONE;
		job.operands_equal = (item.a_re == item.b_re) && (item.a_im == item.b_im);

		case (item.op)
			cna_pkg::OP_NEG: begin
				job.x = -are;
				job.y = -aim;
			end
			cna_pkg::OP_ADD: begin
				job.x = are + bre;
				job.y = aim + bim;
			end
			cna_pkg::OP_SUB: begin
				job.x = are - bre;
				job.y = aim - bim;
			end
			cna_pkg::OP_CONJ: begin
				job.x = are;
				job.y = -aim;
			end
			cna_pkg::OP_MUL: begin
				job.kind = cna_pkg::K_MUL;
				job.x = are;
				job.y = aim;
				job.p = bre;
				job.q = bim;
			end
			cna_pkg::OP_SCALE: begin
				job.kind = cna_pkg::K_SCALE;
				job.x = are;
				job.y = aim;
				job.p = bre;
			end
			cna_pkg::OP_DIV, cna_pkg::OP_RECIP: begin
				if (item.op == cna_pkg::OP_DIV && b_zero) begin
					job.div_zero = 1'b1;
				end else if (!(item.op == cna_pkg::OP_RECIP && a_zero)) begin
					job.kind = cna_pkg::K_SMITH;
					job.swap = swap;
					job.p = swap ? dd : dc;
					job.q = swap ? dc : dd;
					job.x = swap ? ny : nx;
					job.y = swap ? nx : ny;
				end
			end
			cna_pkg::OP_MAG: begin
				if (hi != '0) begin
					job.kind = cna_pkg::K_MAG;
					job.p = hi;
					job.q = lo;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

### sv/cna_fifo.sv
// short job queue between front end and back end
module cna_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cna_pkg::job_t wdata,
	output logic          full,
	input  logic          pop,
	output cna_pkg::job_t rdata,
	output logic          empty
);

	localparam int AW = $clog2(cna_pkg::QUEUE_DEPTH);

	cna_pkg::job_t  mem [cna_pkg::QUEUE_DEPTH];
	logic [AW-1:0]  wp_q, rp_q;
	logic [AW:0]    cnt_q;

	assign full  = (cnt_q == (AW+1)'(cna_pkg::QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem[rp_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) mem[wp_q] <= wdata;
	end

endmodule

### sv/cna_div.sv
// bit-serial fixed-point divider, round to nearest with ties away from zero
module cna_div (
	input  logic              clk,
	input  logic              arst_n,
	input  cna_pkg::div_req_t req,
	output cna_pkg::div_rsp_t rsp
);

	localparam int CW = $clog2(cna_pkg::DVW);

	logic                          busy_q, done_q, neg_q, dz_q;
	logic [CW-1:0]                 cnt_q;
	logic [cna_pkg::DVW-1:0]       dvd_q, quo_q;
	logic [cna_pkg::NMW-1:0]       rem_q, dv_q;
	logic signed [cna_pkg::XW-1:0] abs_n, abs_d, qx;
	logic [cna_pkg::NMW-1:0]       an, ad;
	logic [cna_pkg::NMW:0]         trial, diff;
	logic                          ge;

	// operand magnitudes and one restoring step
	always_comb begin
		abs_n = req.num[cna_pkg::XW-1] ? -req.num : req.num;
		abs_d = req.den[cna_pkg::XW-1] ? -req.den : req.den;
		an = abs_n[cna_pkg::NMW-1:0];
		ad = abs_d[cna_pkg::NMW-1:0];
		trial = {rem_q, dvd_q[cna_pkg::DVW-1]};
		diff = trial - {1'b0, dv_q};
		ge = (trial >= {1'b0, dv_q});
		qx = cna_pkg::XW'(quo_q);
	end

	assign rsp.done = done_q;
	assign rsp.quot = dz_q ? '0 : (neg_q ? -qx : qx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			neg_q  <= 1'b0;
			dz_q   <= 1'b0;
			cnt_q  <= '0;
			dvd_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			dv_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(cna_pkg::DVW - 1);
				dvd_q  <= cna_pkg::DVW'({an, {cna_pkg::FRAC_BITS{1'b0}}})
					+ cna_pkg::DVW'(ad[cna_pkg::NMW-1:1]);
				dv_q   <= ad;
				rem_q  <= '0;
				quo_q  <= '0;
				neg_q  <= req.num[cna_pkg::XW-1] ^ req.den[cna_pkg::XW-1];
				dz_q   <= (ad == '0);
			end else if (busy_q) begin
				rem_q <= ge ? diff[cna_pkg::NMW-1:0] : trial[cna_pkg::NMW-1:0];
				quo_q <= {quo_q[cna_pkg::DVW-2:0], ge};
				dvd_q <= {dvd_q[cna_pkg::DVW-2:0], 1'b0};
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

endmodule

### sv/cna_back.sv
// back end: sequencer over shared multiplier, divider and square root
module cna_back (
	input  logic              clk,
	input  logic              arst_n,
	input  cna_pkg::job_t     head,
	input  logic              empty,
	output logic              pop,
	output cna_pkg::div_req_t div_req,
	input  cna_pkg::div_rsp_t div_rsp,
	output logic              out_valid,
	input  logic              out_stall,
	output cna_pkg::out_t     out_data
);

	localparam int SCW = $clog2(cna_pkg::SRW);

	typedef enum logic [4:0] {
		S_IDLE,
		S_MUL1,
		S_MUL2,
		S_MUL3,
		S_MUL4,
		S_SCL1,
		S_SCL2,
		S_RDIV,
		S_DENI,
		S_DEN,
		S_NRE,
		S_NIM,
		S_QRE,
		S_QIM,
		S_MRR,
		S_MSQ,
		S_SQRT,
		S_SRND,
		S_MHI,
		S_MFIN,
		S_OUT
	} state_t;

	state_t                        state_q;
	cna_pkg::job_t                 j_q;
	logic signed [cna_pkg::PW-1:0] prod_q, acc_q;
	logic signed [cna_pkg::XW-1:0] r_q, den_q, re_q, im_q, t_val;
	logic [cna_pkg::SQW-1:0]       sq_n_q;
	logic [cna_pkg::SRW-1:0]       sq_root_q;
	logic [cna_pkg::SMW-1:0]       sq_rem_q;
	logic [SCW-1:0]                sq_cnt_q;
	logic                          out_valid_q;
	cna_pkg::out_t                 out_q;

	logic signed [cna_pkg::MW-1:0] mul_a, mul_b, r_m;
	logic signed [cna_pkg::XW-1:0] sel_re, sel_im;
	cna_pkg::sat_t                 sat_re, sat_im;
	logic                          can_emit, sel_dz, sel_eq, sq_ge;
	logic [cna_pkg::SMW+1:0]       sq_trial, sq_tst, sq_diff;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign can_emit  = !out_valid_q || !out_stall;
	assign r_m       = $signed(r_q[cna_pkg::MW-1:0]);

	// pop a job: trivial ones only when the output register can take them
	assign pop = (state_q == S_IDLE) && !empty && (head.kind != cna_pkg::K_DONE || can_emit);

	// multiplier operand schedule
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_IDLE: begin
				mul_a = head.x;
				mul_b = head.p;
			end
			S_MUL1: begin
				mul_a = j_q.y;
				mul_b = j_q.q;
			end
			S_MUL2: begin
				mul_a = j_q.x;
				mul_b = j_q.q;
			end
			S_MUL3: begin
				mul_a = j_q.y;
				mul_b = j_q.p;
			end
			S_SCL1: begin
				mul_a = j_q.p;
				mul_b = j_q.y;
			end
			S_DENI: begin
				mul_a = j_q.q;
				mul_b = r_m;
			end
			S_DEN: begin
				mul_a = j_q.y;
				mul_b = r_m;
			end
			S_NRE: begin
				mul_a = j_q.x;
				mul_b = r_m;
			end
			S_MRR: begin
				mul_a = r_m;
				mul_b = r_m;
			end
			S_MHI: begin
				mul_a = j_q.p;
				mul_b = r_m;
			end
			default: begin
			end
		endcase
	end

	// divider requests
	always_comb begin
		div_req.start = 1'b0;
		div_req.num   = cna_pkg::XW'(head.q);
		div_req.den   = cna_pkg::XW'(head.p);
		case (state_q)
			S_IDLE: div_req.start = pop &&
				(head.kind == cna_pkg::K_SMITH || head.kind == cna_pkg::K_MAG);
			S_NIM: begin
				div_req.start = 1'b1;
				div_req.num   = re_q;
				div_req.den   = den_q;
			end
			S_QRE: begin
				div_req.start = div_rsp.done;
				div_req.num   = im_q;
				div_req.den   = den_q;
			end
			default: begin
			end
		endcase
	end

	// square root step and radicand setup
	always_comb begin
		sq_trial = {sq_rem_q, sq_n_q[cna_pkg::SQW-1 -: 2]};
		sq_tst   = {{(cna_pkg::SMW-cna_pkg::SRW){1'b0}}, sq_root_q, 2'b01};
		sq_diff  = sq_trial - sq_tst;
		sq_ge    = (sq_trial >= sq_tst);
		t_val    = cna_pkg::XW'(cna_pkg::ONE_Q) + cna_pkg::qround(prod_q);
	end

	// result selection and saturation
	always_comb begin
		if (state_q == S_IDLE) begin
			sel_re = cna_pkg::XW'(head.x);
			sel_im = cna_pkg::XW'(head.y);
			sel_dz = head.div_zero;
			sel_eq = head.operands_equal;
		end else begin
			sel_re = re_q;
			sel_im = im_q;
			sel_dz = j_q.div_zero;
			sel_eq = j_q.operands_equal;
		end
		sat_re = cna_pkg::saturate(sel_re);
		sat_im = cna_pkg::saturate(sel_im);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			j_q         <= '0;
			prod_q      <= '0;
			acc_q       <= '0;
			r_q         <= '0;
			den_q       <= '0;
			re_q        <= '0;
			im_q        <= '0;
			sq_n_q      <= '0;
			sq_root_q   <= '0;
			sq_rem_q    <= '0;
			sq_cnt_q    <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			prod_q <= mul_a * mul_b;
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (pop) begin
						j_q <= head;
						case (head.kind)
							cna_pkg::K_DONE: begin
								out_q.res_re         <= sat_re.v;
								out_q.res_im         <= sat_im.v;
								out_q.div_zero       <= sel_dz;
								out_q.overflow       <= sat_re.ov | sat_im.ov;
								out_q.operands_equal <= sel_eq;
								out_valid_q          <= 1'b1;
							end
							cna_pkg::K_MUL:   state_q <= S_MUL1;
							cna_pkg::K_SCALE: state_q <= S_SCL1;
							default:          state_q <= S_RDIV;
						endcase
					end
				end
				// complex product, one rounding per part
				S_MUL1: begin
					acc_q   <= prod_q;
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					acc_q   <= acc_q - prod_q;
					state_q <= S_MUL3;
				end
				S_MUL3: begin
					re_q    <= cna_pkg::qround(acc_q);
					acc_q   <= prod_q;
					state_q <= S_MUL4;
				end
				S_MUL4: begin
					im_q    <= cna_pkg::qround(acc_q + prod_q);
					state_q <= S_OUT;
				end
				// real scale
				S_SCL1: begin
					re_q    <= cna_pkg::qround(prod_q);
					state_q <= S_SCL2;
				end
				S_SCL2: begin
					im_q    <= cna_pkg::qround(prod_q);
					state_q <= S_OUT;
				end
				// ratio of the divisor parts, or lo over hi for magnitude
				S_RDIV: begin
					if (div_rsp.done) begin
						r_q     <= div_rsp.quot;
						state_q <= (j_q.kind == cna_pkg::K_MAG) ? S_MRR : S_DENI;
					end
				end
				// smith: denominator and the two numerators
				S_DENI: state_q <= S_DEN;
				S_DEN: begin
					den_q   <= cna_pkg::XW'(j_q.p) + cna_pkg::qround(prod_q);
					state_q <= S_NRE;
				end
				S_NRE: begin
					re_q    <= cna_pkg::XW'(j_q.x) + cna_pkg::qround(prod_q);
					state_q <= S_NIM;
				end
				S_NIM: begin
					im_q    <= cna_pkg::XW'(j_q.y) - cna_pkg::qround(prod_q);
					state_q <= S_QRE;
				end
				S_QRE: begin
					if (div_rsp.done) begin
						re_q    <= div_rsp.quot;
						state_q <= S_QIM;
					end
				end
				S_QIM: begin
					if (div_rsp.done) begin
						im_q    <= j_q.swap ? -div_rsp.quot : div_rsp.quot;
						state_q <= S_OUT;
					end
				end
				// magnitude: sqrt(1 + r*r) then times hi
				S_MRR: state_q <= S_MSQ;
				S_MSQ: begin
					sq_n_q    <= {t_val[cna_pkg::FRAC_BITS+1:0], {cna_pkg::FRAC_BITS{1'b0}}};
					sq_root_q <= '0;
					sq_rem_q  <= '0;
					sq_cnt_q  <= SCW'(cna_pkg::SRW - 1);
					state_q   <= S_SQRT;
				end
				S_SQRT: begin
					sq_rem_q  <= sq_ge ? sq_diff[cna_pkg::SMW-1:0] : sq_trial[cna_pkg::SMW-1:0];
					sq_root_q <= {sq_root_q[cna_pkg::SRW-2:0], sq_ge};
					sq_n_q    <= {sq_n_q[cna_pkg::SQW-3:0], 2'b00};
					if (sq_cnt_q == '0) state_q <= S_SRND;
					else sq_cnt_q <= sq_cnt_q - 1'b1;
				end
				S_SRND: begin
					r_q <= cna_pkg::XW'(sq_root_q)
						+ {{(cna_pkg::XW-1){1'b0}}, (sq_rem_q > cna_pkg::SMW'(sq_root_q))};
					state_q <= S_MHI;
				end
				S_MHI: state_q <= S_MFIN;
				S_MFIN: begin
					re_q    <= cna_pkg::qround(prod_q);
					im_q    <= '0;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (can_emit) begin
						out_q.res_re         <= sat_re.v;
						out_q.res_im         <= sat_im.v;
						out_q.div_zero       <= sel_dz;
						out_q.overflow       <= sat_re.ov | sat_im.ov;
						out_q.operands_equal <= sel_eq;
						out_valid_q          <= 1'b1;
						state_q              <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### sv/complex_number_alu.sv
// Complex ALU on signed Q16.16 operands with one result per transaction, in order.
// Negate, add, subtract, conjugate and the zero special cases (divide by zero,
// reciprocal of zero, magnitude of zero, unknown opcode) finish in the front end and
// go out at one per cycle while the output is not stalled. Multiply and scale run in
// the back end on the single shared 34x34 multiplier. Divide and reciprocal use the
// shared one-bit-per-cycle divider (DVW = 51 quotient bits), which runs three times
// for Smith's method. Magnitude uses one division then a one-bit-per-cycle square root.
// A four-entry queue lets the input side keep accepting while the back end works, and
// the output register holds a stalled result while the back end works on the next job.
module complex_number_alu (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  cna_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_stall,
	output cna_pkg::out_t out_data
);

	cna_pkg::job_t     front_job, head_job;
	cna_pkg::div_req_t div_req;
	cna_pkg::div_rsp_t div_rsp;
	logic              q_full, q_empty, q_pop;

	assign in_stall = q_full;

	cna_front u_front (
		.item (in_data),
		.job  (front_job)
	);

	cna_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (in_valid && !q_full),
		.wdata  (front_job),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (head_job),
		.empty  (q_empty)
	);

	cna_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	cna_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head_job),
		.empty     (q_empty),
		.pop       (q_pop),
		.div_req   (div_req),
		.div_rsp   (div_rsp),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// a divide-by-zero result is zero and never flagged as saturated
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.div_zero |->
			out_data.res_re == '0 && out_data.res_im == '0 && !out_data.overflow)
		else $error("divide by zero result not cleared");

	// the back end never pops an empty queue
	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("pop from empty job queue");

	// a division cannot finish the cycle after it starts
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |=> !div_rsp.done)
		else $error("divider finished too early");

endmodule

### tb/tb_top.sv
// self-checking testbench of the complex alu: directed table then random transactions
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM = 1000;
	localparam int CYCLE_LIMIT = 1000000;
	localparam logic signed [31:0] MAXW = 32'sh7fffffff;
	localparam logic signed [31:0] MINW = 32'sh80000000;
	localparam logic signed [31:0] ONEW = 32'sh00010000;

	typedef logic signed [127:0] wide_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	cna_pkg::in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	cna_pkg::out_t out_data;

	int errors = 0;
	int cycles = 0;
	bit stim_done = 1'b0;
	cna_pkg::out_t expected_results[$];

	complex_number_alu dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	// clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// fixed-point rounding of an exact product, ties toward plus infinity
	function automatic wide_t fx_round(input wide_t p);
		return (p + (wide_t'(1) <<< (cna_pkg::FRAC_BITS - 1))) >>> cna_pkg::FRAC_BITS;
	endfunction

	function automatic wide_t fx_mul(input wide_t a, input wide_t b);
		return fx_round(a * b);
	endfunction

	function automatic wide_t wabs(input wide_t a);
		return (a < 0) ? -a : a;
	endfunction

	// fixed-point quotient, nearest with ties away from zero
	function automatic wide_t fx_div(input wide_t n, input wide_t d);
		wide_t an, ad, q;
		an = wabs(n);
		ad = wabs(d);
		if (ad == 0 || ad >= (wide_t'(1) <<< 63))
			return 0;
		q = ((an <<< cna_pkg::FRAC_BITS) + (ad >>> 1)) / ad;
		return ((n < 0) != (d < 0)) ? -q : q;
	endfunction

	function automatic void smith_div(input wide_t ar, input wide_t ai, input wide_t c,
		input wide_t d, output wide_t re, output wide_t im);
		wide_t r, den;
		if (wabs(d) < wabs(c)) begin
			r = fx_div(d, c);
			den = c + fx_mul(d, r);
			re = fx_div(ar + fx_mul(ai, r), den);
			im = fx_div(ai - fx_mul(ar, r), den);
		end else begin
			r = fx_div(c, d);
			den = d + fx_mul(c, r);
			re = fx_div(ai + fx_mul(ar, r), den);
			im = fx_div(fx_mul(ai, r) - ar, den);
		end
	endfunction

	// rounded integer square root
	function automatic wide_t round_sqrt(input wide_t n);
		wide_t s, b, rem;
		s = 0;
		rem = n;
		b = wide_t'(1) <<< 62;
		while (b > rem) b = b >>> 2;
		while (b != 0) begin
			if (rem >= s + b) begin
				rem = rem - (s + b);
				s = (s >>> 1) + b;
			end else begin
				s = s >>> 1;
			end
			b = b >>> 2;
		end
		return (rem > s) ? s + 1 : s;
	endfunction

	function automatic wide_t hypot_fx(input wide_t ar, input wide_t ai);
		wide_t x, y, hi, lo, r, t;
		x = wabs(ar);
		y = wabs(ai);
		hi = (x < y) ? y : x;
		lo = (x < y) ? x : y;
		if (hi == 0)
			return 0;
		r = fx_div(lo, hi);
		t = (wide_t'(1) <<< cna_pkg::FRAC_BITS) + fx_mul(r, r);
		return fx_mul(hi, round_sqrt(t <<< cna_pkg::FRAC_BITS));
	endfunction

	function automatic logic signed [31:0] clamp_word(input wide_t v, inout logic ov);
		if (v > wide_t'(MAXW)) begin
			ov = 1'b1;
			return MAXW;
		end
		if (v < wide_t'(MINW)) begin
			ov = 1'b1;
			return MINW;
		end
		return v[31:0];
	endfunction

	// predicted result of one transaction
	function automatic cna_pkg::out_t alu_predict(input cna_pkg::in_t t);
		wide_t ar, ai, br, bi, re, im;
		logic ov;
		cna_pkg::out_t o;
		ar = t.a_re;
		ai = t.a_im;
		br = t.b_re;
		bi = t.b_im;
		re = 0;
		im = 0;
		ov = 1'b0;
		o = '0;
		case (t.op)
			cna_pkg::OP_NEG: begin re = -ar; im = -ai; end
			cna_pkg::OP_ADD: begin re = ar + br; im = ai + bi; end
			cna_pkg::OP_SUB: begin re = ar - br; im = ai - bi; end
			cna_pkg::OP_MUL: begin
				re = fx_round(ar * br - ai * bi);
				im = fx_round(ar * bi + ai * br);
			end
			cna_pkg::OP_DIV: begin
				if (br == 0 && bi == 0) o.div_zero = 1'b1;
				else smith_div(ar, ai, br, bi, re, im);
			end
			cna_pkg::OP_CONJ: begin re = ar; im = -ai; end
			cna_pkg::OP_RECIP: begin
				if (!(ar == 0 && ai == 0))
					smith_div(wide_t'(ONEW), 0, ar, ai, re, im);
			end
			cna_pkg::OP_SCALE: begin re = fx_mul(br, ar); im = fx_mul(br, ai); end
			cna_pkg::OP_MAG: re = hypot_fx(ar, ai);
			default: ;
		endcase
		o.res_re = clamp_word(re, ov);
		o.res_im = clamp_word(im, ov);
		o.overflow = ov;
		o.operands_equal = (t.a_re == t.b_re) && (t.a_im == t.b_im);
		return o;
	endfunction

	// directed table; typed expectations only where obvious
	typedef struct {
		cna_pkg::in_t  item;
		bit            typed;
		cna_pkg::out_t want;
	} row_t;

	row_t table_rows[$];

	function automatic row_t mk_row(input logic [3:0] op, input logic signed [31:0] ar,
		input logic signed [31:0] ai, input logic signed [31:0] br,
		input logic signed [31:0] bi, input bit typed, input cna_pkg::out_t want);
		row_t r;
		r.item = '{op: op, a_re: ar, a_im: ai, b_re: br, b_im: bi};
		r.typed = typed;
		r.want = want;
		return r;
	endfunction

	function automatic cna_pkg::out_t mk_out(input logic signed [31:0] re,
		input logic signed [31:0] im, input logic dz, input logic ov, input logic eq);
		cna_pkg::out_t o;
		o = '{res_re: re, res_im: im, div_zero: dz, overflow: ov, operands_equal: eq};
		return o;
	endfunction

	initial begin
		// negation of the most negative value
		table_rows.push_back(mk_row(cna_pkg::OP_NEG, MINW, MINW, 0, 0, 1,
			mk_out(MAXW, MAXW, 0, 1, 0)));
		table_rows.push_back(mk_row(cna_pkg::OP_NEG, MAXW, 0, 0, 0, 1,
			mk_out(-MAXW, 0, 0, 0, 0)));
		table_rows.push_back(mk_row(cna_pkg::OP_ADD, MAXW, MINW, MAXW, MINW, 1,
			mk_out(MAXW, MINW, 0, 1, 1)));
		table_rows.push_back(mk_row(cna_pkg::OP_SUB, MINW, MAXW, MAXW, MINW, 1,
			mk_out(MINW, MAXW, 0, 1, 0)));
		table_rows.push_back(mk_row(cna_pkg::OP_MUL, MAXW, MAXW, MAXW, MINW, 0, '0));
		table_rows.push_back(mk_row(cna_pkg::OP_MUL, ONEW, ONEW, ONEW, -ONEW, 0, '0));
		// divide by zero
		table_rows.push_back(mk_row(cna_pkg::OP_DIV, MAXW, MINW, 0, 0, 1,
			mk_out(0, 0, 1, 0, 0)));
		table_rows.push_back(mk_row(cna_pkg::OP_DIV, 0, 0, 0, 0, 1, mk_out(0, 0, 1, 0, 1)));
		table_rows.push_back(mk_row(cna_pkg::OP_DIV, ONEW, 0, 0, ONEW, 0, '0));
		table_rows.push_back(mk_row(cna_pkg::OP_DIV, MAXW, MAXW, 1, 1, 0, '0));
		table_rows.push_back(mk_row(cna_pkg::OP_DIV, MINW, 5, MINW, MAXW, 0, '0));
		table_rows.push_back(mk_row(cna_pkg::OP_CONJ, MINW, MINW, 7, 7, 1,
			mk_out(MINW, MAXW, 0, 1, 0)));
		// reciprocal of zero
		table_rows.push_back(mk_row(cna_pkg::OP_RECIP, 0, 0, 3, 3, 1, mk_out(0, 0, 0, 0, 0)));
		table_rows.push_back(mk_row(cna_pkg::OP_RECIP, 1, 0, 0, 0, 0, '0));
		table_rows.push_back(mk_row(cna_pkg::OP_RECIP, MINW, MAXW, 0, 0, 0, '0));
		table_rows.push_back(mk_row(cna_pkg::OP_SCALE, MAXW, MINW, MINW, 9, 0, '0));
		table_rows.push_back(mk_row(cna_pkg::OP_SCALE, ONEW, -ONEW, ONEW, MAXW, 0, '0));
		// magnitude
		table_rows.push_back(mk_row(cna_pkg::OP_MAG, 0, 0, 4, 4, 1, mk_out(0, 0, 0, 0, 0)));
		table_rows.push_back(mk_row(cna_pkg::OP_MAG, MINW, MINW, 0, 0, 1,
			mk_out(MAXW, 0, 0, 1, 0)));
		table_rows.push_back(mk_row(cna_pkg::OP_MAG, 3 * ONEW, -4 * ONEW, 0, 0, 0, '0));
		// unknown opcodes
		table_rows.push_back(mk_row(4'd9, MAXW, MAXW, MAXW, MAXW, 1, mk_out(0, 0, 0, 0, 1)));
		table_rows.push_back(mk_row(4'd15, MINW, 1, 2, 3, 1, mk_out(0, 0, 0, 0, 0)));
	end

	function automatic logic signed [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return MAXW;
			1: return MINW;
			2: return $signed($urandom_range(0, 6)) - 3;
			3: return $signed($urandom_range(0, 8 * 65536)) - 4 * 65536;
			default: return $urandom;
		endcase
	endfunction

	function automatic cna_pkg::in_t rand_item();
		cna_pkg::in_t t;
		t.op = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
		t.a_re = rand_word();
		t.a_im = rand_word();
		t.b_re = rand_word();
		t.b_im = rand_word();
		case ($urandom_range(0, 9))
			0: begin t.b_re = 0; t.b_im = 0; end
			1: begin t.b_re = t.a_re; t.b_im = t.a_im; end
			2: begin t.a_re = 0; t.a_im = 0; end
			default: ;
		endcase
		return t;
	endfunction

	// send one transaction after a random gap; holds valid until accepted
	task automatic send_item(input cna_pkg::in_t t);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= t;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_results.push_back(alu_predict(t));
	endtask

	// stimulus
	initial begin
		cna_pkg::in_t t;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (table_rows[i]) begin
			send_item(table_rows[i].item);
			if (table_rows[i].typed) begin
				void'(expected_results.pop_back());
				expected_results.push_back(table_rows[i].want);
			end
		end
		for (int n = 0; n < N_RANDOM; n++) begin
			// drain the pipe once midway
			if (n == N_RANDOM / 2) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (expected_results.size() != 0) @(posedge clk);
			end
			t = rand_item();
			send_item(t);
		end
		in_valid <= 1'b0;
		stim_done = 1'b1;
	end

	// receiver stall pattern
	initial begin
		int wait_cycles;
		@(posedge arst_n);
		forever begin
			wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
			out_stall <= (wait_cycles != 0);
			repeat (wait_cycles) @(posedge clk);
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// compare each accepted transaction with the oldest prediction
	always @(posedge clk) begin
		cna_pkg::out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$display("%0t unexpected transaction: actual %p", $time, out_data);
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (out_data.res_re !== want.res_re)
					$display("%0t res_re expected %h actual %h", $time, want.res_re, out_data.res_re);
				if (out_data.res_im !== want.res_im)
					$display("%0t res_im expected %h actual %h", $time, want.res_im, out_data.res_im);
				if (out_data.div_zero !== want.div_zero)
					$display("%0t div_zero expected %b actual %b", $time, want.div_zero,
						out_data.div_zero);
				if (out_data.overflow !== want.overflow)
					$display("%0t overflow expected %b actual %b", $time, want.overflow,
						out_data.overflow);
				if (out_data.operands_equal !== want.operands_equal)
					$display("%0t operands_equal expected %b actual %b", $time,
						want.operands_equal, out_data.operands_equal);
				if (out_data !== want)
					errors++;
			end
		end
	end

	// end of run and watchdog
	initial begin
		@(posedge arst_n);
		while (!(stim_done && expected_results.size() == 0) && cycles < CYCLE_LIMIT)
			@(posedge clk);
		if (cycles < CYCLE_LIMIT)
			repeat (400) @(posedge clk);
		if (cycles >= CYCLE_LIMIT || errors != 0 || expected_results.size() != 0)
			$display("status: fail");
		else
			$display("status: pass");
		$finish;
	end

	always @(posedge clk) cycles <= cycles + 1;

endmodule
